// ===== rtl/bspd_pkg.sv =====
// shared types and constants for the button stepped pwm duty block
package bspd_pkg;

  localparam int CFG_W          = 16;
  localparam int CFG_AW         = 1;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int Q_DEPTH        = 2;
  localparam int TENS_W         = 4;
  localparam int PROD_W         = CFG_W + TENS_W;
  localparam int OUT_W          = 40;
  localparam int IN_W           = 8;

  // register indexes on the config port
  localparam logic [CFG_AW-1:0] REG_PERIOD_TOP = 1'b0;
  localparam logic [CFG_AW-1:0] REG_DEBOUNCE   = 1'b1;

  localparam logic [CFG_W-1:0] TOP_RESET = 16'd15624;
  localparam logic [CFG_W-1:0] DEB_RESET = 16'd781;
  localparam logic [CFG_W-1:0] CMP_RESET = 16'd1562;

  // duty is kept in tens of percent
  localparam logic [TENS_W-1:0] TENS_MIN = 4'd1;
  localparam logic [TENS_W-1:0] TENS_MAX = 4'd10;
  localparam logic [6:0]        DUTY_STEP = 7'd10;

  // floor(x / 10) = (x * DIV10_RECIP) >> DIV10_SHIFT, exact for x below 2**22
  localparam logic [PROD_W-1:0] DIV10_RECIP = 20'hCCCCD;
  localparam int                DIV10_SHIFT = 23;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PRESS,
    PH_REL_WAIT,
    PH_RELEASE
  } phase_t;

  typedef struct packed {
    logic down_pr;
    logic up_pr;
  } item_t;

  typedef struct packed {
    logic              start;
    logic              load_act;
    logic [CFG_W-1:0]  top;
    logic [TENS_W-1:0] tens;
  } cmp_req_t;

  typedef struct packed {
    logic             valid;
    logic             load_act;
    logic [CFG_W-1:0] value;
  } cmp_rsp_t;

endpackage

// ===== rtl/button_stepped_pwm_duty.sv =====
// top level of the button stepped pwm duty block
// Each input beat is one prescaled timer tick carrying the two active-low
// button levels, and each tick yields one output beat with the pwm level, the
// duty in percent, the active compare value and the counter value. A tick
// normally follows the last one back to back. A tick that steps the
// duty, and a period_top write, start the compare unit: the product is
// registered, then divided by ten and loaded into the pending compare on the
// following edge. The next tick is held until that load, while the two-beat
// input queue keeps taking beats. The compare value loads into the active
// register at the counter wrap. Write the config registers only while no tick
// is in flight.
module button_stepped_pwm_duty #(
  parameter int COUNT_WIDTH = bspd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [bspd_pkg::IN_W-1:0]    in_tdata,   // up_button_level, down_button_level
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [bspd_pkg::OUT_W-1:0]   out_tdata,  // pwm_level, duty_now, compare_value, count_value
  input  logic                         cfg_we,
  input  logic [bspd_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [bspd_pkg::CFG_W-1:0]   cfg_data
);

  logic               q_valid;
  logic               q_ready;
  bspd_pkg::item_t    q_item;
  bspd_pkg::cmp_req_t cmp_req;
  bspd_pkg::cmp_rsp_t cmp_rsp;

  bspd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_ready   (q_ready)
  );

  bspd_cmp_unit u_cmp (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cmp_req),
    .rsp   (cmp_rsp)
  );

  bspd_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_ready    (q_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .cmp_req    (cmp_req),
    .cmp_rsp    (cmp_rsp)
  );

endmodule

// ===== rtl/bspd_front.sv =====
// input side: takes tick beats, decodes button presses, two-entry queue to the back
module bspd_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [bspd_pkg::IN_W-1:0]  in_tdata,
  output logic                       q_valid,
  output bspd_pkg::item_t            q_item,
  input  logic                       q_ready
);

  bspd_pkg::item_t mem_r [bspd_pkg::Q_DEPTH];
  logic [1:0]      cnt_r, cnt_nxt;
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic            push, pop;
  bspd_pkg::item_t in_item;

  // buttons are active low
  assign in_item.up_pr   = ~in_tdata[0];
  assign in_item.down_pr = ~in_tdata[1];

  assign in_tready = (cnt_r != 2'(bspd_pkg::Q_DEPTH));
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = mem_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  always_comb begin
    cnt_nxt    = cnt_r;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

// ===== rtl/bspd_cmp_unit.sv =====
// two-stage compare computation: top * tens, then divide by ten via reciprocal
module bspd_cmp_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  bspd_pkg::cmp_req_t  req,
  output bspd_pkg::cmp_rsp_t  rsp
);

  logic [bspd_pkg::PROD_W-1:0]   prod_r;
  logic                          v1_r;
  logic                          ld1_r;
  logic [2*bspd_pkg::PROD_W-1:0] scaled;

  assign scaled = (2*bspd_pkg::PROD_W)'(prod_r)
                * (2*bspd_pkg::PROD_W)'(bspd_pkg::DIV10_RECIP);

  assign rsp.valid    = v1_r;
  assign rsp.load_act = ld1_r;
  assign rsp.value    = bspd_pkg::CFG_W'(scaled >> bspd_pkg::DIV10_SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= req.start;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      prod_r <= bspd_pkg::PROD_W'(req.top) * bspd_pkg::PROD_W'(req.tens);
      ld1_r  <= req.load_act;
    end
  end

endmodule

// ===== rtl/bspd_back.sv =====
// tick side: debounce sequencer, timer counter, compare buffering, output register
module bspd_back #(
  parameter int COUNT_WIDTH = bspd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  bspd_pkg::item_t              q_item,
  output logic                         q_ready,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [bspd_pkg::OUT_W-1:0]   out_tdata,
  input  logic                         cfg_we,
  input  logic [bspd_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [bspd_pkg::CFG_W-1:0]   cfg_data,
  output bspd_pkg::cmp_req_t           cmp_req,
  input  bspd_pkg::cmp_rsp_t           cmp_rsp
);

  localparam int TOP_W = (COUNT_WIDTH < bspd_pkg::CFG_W) ? COUNT_WIDTH : bspd_pkg::CFG_W;
  localparam int CW    = bspd_pkg::CFG_W;
  localparam int TW    = bspd_pkg::TENS_W;

  logic [TOP_W-1:0]       top_r, top_nxt;
  logic [CW-1:0]          deb_r, deb_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0]          act_r, act_nxt;
  logic [CW-1:0]          pend_r, pend_nxt;
  logic [TW-1:0]          tens_r, tens_nxt;
  bspd_pkg::phase_t       phase_r, phase_nxt;
  logic                   sdown_r, sdown_nxt;
  logic [CW-1:0]          wait_r, wait_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [bspd_pkg::OUT_W-1:0] out_data_r, out_data_nxt;

  logic          fire;
  logic          wrap;
  logic          served_pr;
  logic [CW-1:0] wait_inc;
  logic          wait_done;
  logic          step_go;
  logic          pwm;

  // compare pipeline busy holds ticks so the new compare is in place first
  assign fire    = q_valid && !cmp_rsp.valid && (!out_valid_r || out_tready);
  assign q_ready = fire;
  assign wrap    = (cnt_r >= COUNT_WIDTH'(top_r));
  assign pwm     = (32'(cnt_r) <= 32'(act_r));

  assign served_pr = sdown_r ? q_item.down_pr : q_item.up_pr;
  assign wait_inc  = (wait_r == '1) ? wait_r : wait_r + CW'(1);
  assign wait_done = (wait_inc >= deb_r);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    top_nxt       = top_r;
    deb_nxt       = deb_r;
    cnt_nxt       = cnt_r;
    act_nxt       = act_r;
    pend_nxt      = pend_r;
    tens_nxt      = tens_r;
    phase_nxt     = phase_r;
    sdown_nxt     = sdown_r;
    wait_nxt      = wait_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    step_go       = 1'b0;
    cmp_req       = '0;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (fire) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {16'(cnt_r), act_r, 7'(tens_r) * bspd_pkg::DUTY_STEP, pwm};

      unique case (phase_r)
        bspd_pkg::PH_IDLE: begin
          if (q_item.up_pr) begin
            sdown_nxt = 1'b0;
            phase_nxt = bspd_pkg::PH_PRESS;
            wait_nxt  = '0;
          end else if (q_item.down_pr) begin
            sdown_nxt = 1'b1;
            phase_nxt = bspd_pkg::PH_PRESS;
            wait_nxt  = '0;
          end
        end
        bspd_pkg::PH_PRESS: begin
          wait_nxt = wait_inc;
          if (wait_done) begin
            phase_nxt = served_pr ? bspd_pkg::PH_REL_WAIT : bspd_pkg::PH_IDLE;
          end
        end
        bspd_pkg::PH_REL_WAIT: begin
          if (!served_pr) begin
            phase_nxt = bspd_pkg::PH_RELEASE;
            wait_nxt  = '0;
          end
        end
        bspd_pkg::PH_RELEASE: begin
          wait_nxt = wait_inc;
          if (wait_done) begin
            phase_nxt = bspd_pkg::PH_IDLE;
            if (sdown_r) begin
              if (tens_r > bspd_pkg::TENS_MIN) begin
                tens_nxt = tens_r - TW'(1);
                step_go  = 1'b1;
              end
            end else if (tens_r < bspd_pkg::TENS_MAX) begin
              tens_nxt = tens_r + TW'(1);
              step_go  = 1'b1;
            end
          end
        end
        default: begin
          phase_nxt = bspd_pkg::PH_IDLE;
        end
      endcase

      if (wrap) begin
        cnt_nxt = '0;
        act_nxt = pend_r;
      end else begin
        cnt_nxt = cnt_r + COUNT_WIDTH'(1);
      end

      // a step on a wrapping tick also lands in the active compare when done
      if (step_go) begin
        cmp_req.start    = 1'b1;
        cmp_req.load_act = wrap;
        cmp_req.top      = CW'(top_r);
        cmp_req.tens     = tens_nxt;
      end
    end

    if (cmp_rsp.valid) begin
      pend_nxt = cmp_rsp.value;
      if (cmp_rsp.load_act) begin
        act_nxt = cmp_rsp.value;
      end
    end

    if (cfg_we) begin
      unique case (cfg_addr)
        bspd_pkg::REG_PERIOD_TOP: begin
          top_nxt          = TOP_W'(cfg_data);
          cmp_req.start    = 1'b1;
          cmp_req.load_act = 1'b0;
          cmp_req.top      = CW'(TOP_W'(cfg_data));
          cmp_req.tens     = tens_r;
        end
        bspd_pkg::REG_DEBOUNCE: begin
          deb_nxt = cfg_data;
        end
        default: begin
          deb_nxt = deb_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r       <= TOP_W'(bspd_pkg::TOP_RESET);
      deb_r       <= bspd_pkg::DEB_RESET;
      cnt_r       <= '0;
      act_r       <= bspd_pkg::CMP_RESET;
      pend_r      <= bspd_pkg::CMP_RESET;
      tens_r      <= bspd_pkg::TENS_MIN;
      phase_r     <= bspd_pkg::PH_IDLE;
      sdown_r     <= 1'b0;
      wait_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      top_r       <= top_nxt;
      deb_r       <= deb_nxt;
      cnt_r       <= cnt_nxt;
      act_r       <= act_nxt;
      pend_r      <= pend_nxt;
      tens_r      <= tens_nxt;
      phase_r     <= phase_nxt;
      sdown_r     <= sdown_nxt;
      wait_r      <= wait_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== rtl/bspd_checker.sv =====
// port-level checks for the button stepped pwm duty block, bound to the top level
module bspd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic [bspd_pkg::IN_W-1:0]    in_tdata,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [bspd_pkg::OUT_W-1:0]   out_tdata
);

  // an offered tick beat holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("tick beat changed while waiting");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // pwm level agrees with the count and compare fields of the same beat
  a_pwm_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[39:24] <= out_tdata[23:8])))
    else $error("pwm level disagrees with count and compare");

  // duty stays in its range
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:1] >= 7'd10) && (out_tdata[7:1] <= 7'd100))
    else $error("duty out of range");

  // no result beat right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind button_stepped_pwm_duty bspd_checker u_bspd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the button stepped pwm duty block
`timescale 1ns / 1ps

module testbench;

  localparam int          HALF_PERIOD  = 6;
  localparam int          RESET_CYCLES = 7;
  localparam int          TARGET_TICKS = 1250;
  localparam int          IDLE_LIMIT   = 2000;
  localparam int          HOLD_CYCLES  = 150;
  localparam logic [6:0]  DUTY_FLOOR   = 7'd10;
  localparam logic [6:0]  DUTY_CEIL    = 7'd100;

  // one output beat, first field in the highest bits
  typedef struct packed {
    logic [15:0] count;
    logic [15:0] compare;
    logic [6:0]  duty;
    logic        pwm;
  } tick_result_t;

  class pwm_tick_tracker;
    logic [15:0]      top;
    logic [15:0]      deb;
    logic [15:0]      count;
    logic [15:0]      cmp_act;
    logic [15:0]      cmp_pend;
    logic [6:0]       duty;
    bspd_pkg::phase_t phase;
    logic             serving_down;
    logic [15:0]      wait_cnt;
    tick_result_t     expected_ticks[$];
    int               errors;
    int               checked;

    function new();
      top          = bspd_pkg::TOP_RESET;
      deb          = bspd_pkg::DEB_RESET;
      count        = '0;
      cmp_act      = bspd_pkg::CMP_RESET;
      cmp_pend     = bspd_pkg::CMP_RESET;
      duty         = DUTY_FLOOR;
      phase        = bspd_pkg::PH_IDLE;
      serving_down = 1'b0;
      wait_cnt     = '0;
      errors       = 0;
      checked      = 0;
    endfunction

    function logic [15:0] scaled_compare();
      logic [31:0] prod;
      prod = {16'b0, top} * {25'b0, duty};
      return 16'(prod / 32'd100);
    endfunction

    function bit wait_done();
      if (wait_cnt != 16'hFFFF) wait_cnt++;
      return wait_cnt >= deb;
    endfunction

    function void set_reg(logic [bspd_pkg::CFG_AW-1:0] addr,
                          logic [bspd_pkg::CFG_W-1:0] data);
      if (addr == bspd_pkg::REG_PERIOD_TOP) begin
        top      = data;
        cmp_pend = scaled_compare();
      end else begin
        deb = data;
      end
    endfunction

    function int pending();
      return expected_ticks.size();
    endfunction

    // predicts the beat for one accepted tick and advances the state
    function void note_tick(logic up, logic down);
      tick_result_t r;
      logic served;
      r.pwm     = (count <= cmp_act);
      r.duty    = duty;
      r.compare = cmp_act;
      r.count   = count;
      expected_ticks.push_back(r);

      served = serving_down ? down : up;
      case (phase)
        bspd_pkg::PH_IDLE: begin
          if (!up) begin
            serving_down = 1'b0;
            phase        = bspd_pkg::PH_PRESS;
            wait_cnt     = '0;
          end else if (!down) begin
            serving_down = 1'b1;
            phase        = bspd_pkg::PH_PRESS;
            wait_cnt     = '0;
          end
        end
        bspd_pkg::PH_PRESS: begin
          if (wait_done()) phase = served ? bspd_pkg::PH_IDLE : bspd_pkg::PH_REL_WAIT;
        end
        bspd_pkg::PH_REL_WAIT: begin
          if (served) begin
            phase    = bspd_pkg::PH_RELEASE;
            wait_cnt = '0;
          end
        end
        default: begin
          if (wait_done()) begin
            // a step past either duty limit is dropped
            if (serving_down && duty > DUTY_FLOOR) begin
              duty     = duty - bspd_pkg::DUTY_STEP;
              cmp_pend = scaled_compare();
            end else if (!serving_down && duty < DUTY_CEIL) begin
              duty     = duty + bspd_pkg::DUTY_STEP;
              cmp_pend = scaled_compare();
            end
            phase = bspd_pkg::PH_IDLE;
          end
        end
      endcase

      if (count >= top) begin
        count   = '0;
        cmp_act = cmp_pend;
      end else begin
        count = count + 16'd1;
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("mismatch on beat %0d: %s", checked, msg);
    endtask

    task check_tick(tick_result_t got);
      tick_result_t want;
      checked++;
      if (expected_ticks.size() == 0) begin
        report("output beat with no tick pending");
        return;
      end
      want = expected_ticks.pop_front();
      if (got.pwm != want.pwm)
        report($sformatf("pwm_level %0d, want %0d", got.pwm, want.pwm));
      if (got.duty != want.duty)
        report($sformatf("duty_now %0d, want %0d", got.duty, want.duty));
      if (got.compare != want.compare)
        report($sformatf("compare_value %0d, want %0d", got.compare, want.compare));
      if (got.count != want.count)
        report($sformatf("count_value %0d, want %0d", got.count, want.count));
    endtask
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [bspd_pkg::IN_W-1:0]     in_tdata;   // up_button_level, down_button_level
  logic                          out_tvalid;
  logic                          out_tready;
  logic [bspd_pkg::OUT_W-1:0]    out_tdata;  // pwm_level, duty_now, compare_value, count_value
  logic                          cfg_we;
  logic [bspd_pkg::CFG_AW-1:0]   cfg_addr;
  logic [bspd_pkg::CFG_W-1:0]    cfg_data;

  pwm_tick_tracker tracker = new();
  int  ticks_sent;
  int  idle_cycles;
  bit  sender_burst;

  button_stepped_pwm_duty dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = bspd_pkg::REG_PERIOD_TOP;
    cfg_data   = '0;
  end

  always #(HALF_PERIOD) clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_tick(tick_result_t'(out_tdata));
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("button_stepped_pwm_duty verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stalls, bursts of steady ready, one long hold-off
  initial begin
    int  stall;
    bit  burst;
    bit  held;
    stall = 0;
    burst = 1'b0;
    held  = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && tracker.checked >= 400 && in_tvalid) begin
        held  = 1'b1;
        stall = HOLD_CYCLES;
      end else if (stall == 0 && !burst && $urandom_range(0, 5) == 0) begin
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
      if ($urandom_range(0, 199) == 0) burst = !burst;
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic int sender_gap();
    int r;
    if ($urandom_range(0, 99) == 0) sender_burst = !sender_burst;
    if (sender_burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic drive_tick(input logic up, input logic down);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(bspd_pkg::IN_W - 2){1'b0}}, down, up};
    do @(posedge clk); while (!in_tready);
    tracker.note_tick(up, down);
    ticks_sent++;
  endtask

  task automatic drain_ticks();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bspd_pkg::CFG_AW-1:0] addr,
                           input logic [bspd_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(posedge clk);
    tracker.set_reg(addr, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // one press and release of a button; a clean press and the release are held past debounce for settings up to six
  task automatic press_release(input logic use_down, input bit clean);
    int hold;
    int deb_ticks;
    deb_ticks = (tracker.deb > 6) ? 6 : int'(tracker.deb);
    hold = clean ? deb_ticks + 1 + $urandom_range(0, 2) : 1;
    for (int i = 0; i < hold; i++) begin
      if (use_down) drive_tick((i == 0) ? 1'b1 : 1'($urandom), 1'b0);
      else          drive_tick(1'b0, 1'($urandom));
    end
    hold = deb_ticks + 1 + $urandom_range(0, 2);
    for (int i = 0; i < hold; i++) begin
      if (use_down) drive_tick($urandom_range(0, 3) != 0, 1'b1);
      else          drive_tick(1'b1, $urandom_range(0, 3) != 0);
    end
  endtask

  initial begin
    logic [15:0] new_top;
    logic [15:0] new_deb;
    bit          up_bias;
    int          phase_end;
    int          r;
    ticks_sent   = 0;
    sender_burst = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings, every button combination
    drive_tick(1'b1, 1'b1);
    drive_tick(1'b0, 1'b1);
    drive_tick(1'b1, 1'b0);
    drive_tick(1'b0, 1'b0);
    drain_ticks();

    // zero top and zero debounce: step below floor, up step, both pressed
    write_reg(bspd_pkg::REG_PERIOD_TOP, 16'd0);
    write_reg(bspd_pkg::REG_DEBOUNCE, 16'd0);
    drive_tick(1'b1, 1'b1);
    drive_tick(1'b1, 1'b0);
    drive_tick(1'b1, 1'b0);
    drive_tick(1'b1, 1'b1);
    drive_tick(1'b1, 1'b1);
    drive_tick(1'b0, 1'b1);
    drive_tick(1'b0, 1'b1);
    drive_tick(1'b1, 1'b1);
    drive_tick(1'b1, 1'b1);
    drive_tick(1'b0, 1'b0);
    drive_tick(1'b0, 1'b1);
    drive_tick(1'b1, 1'b0);
    drive_tick(1'b1, 1'b0);
    drive_tick(1'b1, 1'b0);
    drain_ticks();

    write_reg(bspd_pkg::REG_PERIOD_TOP, 16'hFFFF);
    write_reg(bspd_pkg::REG_DEBOUNCE, 16'hFFFF);
    drive_tick(1'b0, 1'b1);
    drive_tick(1'b1, 1'b1);
    drive_tick(1'b0, 1'b0);
    drain_ticks();

    // top lowered below the running counter
    write_reg(bspd_pkg::REG_PERIOD_TOP, 16'd1);
    write_reg(bspd_pkg::REG_DEBOUNCE, 16'd1);
    drive_tick(1'b1, 1'b1);
    drive_tick(1'b1, 1'b1);
    drain_ticks();

    while (ticks_sent < TARGET_TICKS) begin
      r = $urandom_range(0, 9);
      case (r)
        0:       new_top = 16'd0;
        1:       new_top = 16'd1;
        2:       new_top = 16'hFFFF;
        3:       new_top = 16'($urandom);
        default: new_top = 16'($urandom_range(2, 40));
      endcase
      r = $urandom_range(0, 19);
      case (r)
        0, 1:    new_deb = 16'd0;
        2:       new_deb = 16'hFFFF;
        3:       new_deb = 16'($urandom);
        default: new_deb = 16'($urandom_range(0, 4));
      endcase
      r = $urandom_range(0, 2);
      if (r != 1) write_reg(bspd_pkg::REG_PERIOD_TOP, new_top);
      if (r != 0) write_reg(bspd_pkg::REG_DEBOUNCE, new_deb);

      up_bias   = 1'($urandom);
      phase_end = ticks_sent + $urandom_range(40, 120);
      while (ticks_sent < phase_end) begin
        r = $urandom_range(0, 9);
        if (r < 7) begin
          press_release(($urandom_range(0, 4) == 0) ? up_bias : !up_bias, 1'b1);
        end else if (r == 7) begin
          press_release(1'($urandom), 1'b0);
        end else begin
          repeat ($urandom_range(1, 5)) drive_tick(1'($urandom), 1'($urandom));
        end
      end
      drain_ticks();
    end

    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("button_stepped_pwm_duty verification clean");
    end else begin
      $display("button_stepped_pwm_duty verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bspd_pkg.sv
rtl/bspd_front.sv
rtl/bspd_cmp_unit.sv
rtl/bspd_back.sv
rtl/button_stepped_pwm_duty.sv
rtl/bspd_checker.sv
tb/sv/testbench.sv
